/* rtl/chfd_pkg.sv */
// ============================================================================
// chfd_pkg
// Shared types, constants and the CRC-16 byte step for the header deframer.
// ============================================================================
`default_nettype none

package chfd_pkg;

    localparam int MAX_FRAME_LEN = 64;
    localparam int MIN_FRAME_LEN = 12;
    localparam int PTR_W         = $clog2(MAX_FRAME_LEN);
    localparam int CNT_W         = $clog2(MAX_FRAME_LEN + 1);

    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Register reset values
    localparam logic [6:0] FRAME_LEN_RST = 7'd32;
    localparam logic [7:0] HEADER_RST    = 8'h53;
    localparam logic [5:0] YAW_OFF_RST   = 6'd2;
    localparam logic [5:0] PITCH_OFF_RST = 6'd6;

    // Register indexes (word address bits [3:2])
    localparam logic [1:0] REG_FRAME_LEN = 2'd0;
    localparam logic [1:0] REG_HEADER    = 2'd1;
    localparam logic [1:0] REG_YAW_OFF   = 2'd2;
    localparam logic [1:0] REG_PITCH_OFF = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT
    } chfd_state_t;

    // Reflected CRC-16 update over one byte, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/chfd_ram.sv */
// ============================================================================
// chfd_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module chfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/crc16_header_frame_deframer.sv */
// ============================================================================
// crc16_header_frame_deframer
// Hunts a byte stream for header-led frames with a reflected CRC-16 trailer
// and returns the yaw and pitch words of every frame that checks.
// ============================================================================
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, rx_byte[7:0]          | in
//  output  | out_valid, out_ready, yaw_bits, pitch_bits| out
//  config  | psel, penable, pwrite, paddr[3:0], pwdata,| in/out
//          | prdata, pready                            |
//
// A byte is written into the window in ST_IDLE. Each frame attempt then
// issues the first read in ST_CHECK and streams up to L bytes of the
// window through the CRC in ST_SCAN, one byte per cycle from the single RAM
// read port (L is the effective frame length). A good frame is handed to
// the output in ST_EMIT. The window is a circular buffer tracked by a head
// pointer and a fill count, so reset needs no clearing pass. A stalled
// output word holds the block only when the next frame is ready to be
// emitted.
// ============================================================================
`default_nettype none

module crc16_header_frame_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    // frame output
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [31:0] yaw_bits,
    output logic      [31:0] pitch_bits,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import chfd_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0] frame_length_reg;
    logic [7:0] header_byte_reg;
    logic [5:0] yaw_offset_reg;
    logic [5:0] pitch_offset_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FRAME_LEN_RST;
            header_byte_reg  <= HEADER_RST;
            yaw_offset_reg   <= YAW_OFF_RST;
            pitch_offset_reg <= PITCH_OFF_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_FRAME_LEN: frame_length_reg <= pwdata[6:0];
                REG_HEADER:    header_byte_reg  <= pwdata[7:0];
                REG_YAW_OFF:   yaw_offset_reg   <= pwdata[5:0];
                REG_PITCH_OFF: pitch_offset_reg <= pwdata[5:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FRAME_LEN: prdata = {25'd0, frame_length_reg};
            REG_HEADER:    prdata = {24'd0, header_byte_reg};
            REG_YAW_OFF:   prdata = {26'd0, yaw_offset_reg};
            REG_PITCH_OFF: prdata = {26'd0, pitch_offset_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Saturate the frame length to the supported range
    logic [CNT_W-1:0] frame_len;
    logic [CNT_W-1:0] payload_len;
    always_comb
    begin
        if (frame_length_reg < 7'(MIN_FRAME_LEN))
            frame_len = CNT_W'(MIN_FRAME_LEN);
        else if (frame_length_reg > 7'(MAX_FRAME_LEN))
            frame_len = CNT_W'(MAX_FRAME_LEN);
        else
            frame_len = CNT_W'(frame_length_reg);
        payload_len = frame_len - CNT_W'(2);
    end

    // ------------------------------------------------------------------
    // Window storage: circular buffer in a RAM
    // ------------------------------------------------------------------
    chfd_state_t      state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] idx_reg, idx_next;     // window index of rdata in SCAN
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic [31:0]      yaw_acc_reg, yaw_acc_next;
    logic [31:0]      pitch_acc_reg, pitch_acc_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      yaw_out_reg, yaw_out_next;
    logic [31:0]      pitch_out_reg, pitch_out_next;

    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [PTR_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    chfd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_LEN)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Word captures during the CRC pass
    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] yaw_dist;
    logic [CNT_W-1:0] pitch_dist;
    logic             yaw_hit;
    logic             pitch_hit;

    always_comb
    begin
        idx_ext    = CNT_W'(idx_reg);
        yaw_dist   = idx_ext - CNT_W'(yaw_offset_reg);
        pitch_dist = idx_ext - CNT_W'(pitch_offset_reg);
        yaw_hit    = (idx_ext >= CNT_W'(yaw_offset_reg)) && (yaw_dist < CNT_W'(4));
        pitch_hit  = (idx_ext >= CNT_W'(pitch_offset_reg)) && (pitch_dist < CNT_W'(4));
    end

    logic in_fire;
    assign in_fire  = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        crc_lo_next    = crc_lo_reg;
        yaw_acc_next   = yaw_acc_reg;
        pitch_acc_next = pitch_acc_reg;
        yaw_out_next   = yaw_out_reg;
        pitch_out_next = pitch_out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_waddr      = head_reg + PTR_W'(fill_reg);
        ram_raddr      = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // Window full: drop the oldest byte, its slot takes the new one
                    if (fill_reg == CNT_W'(MAX_FRAME_LEN))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = head_reg;
                        head_next = head_reg + PTR_W'(1);
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                // Issue the read of the front byte and arm the pass
                ram_raddr      = head_reg;
                idx_next       = '0;
                crc_next       = CRC_INIT;
                yaw_acc_next   = '0;
                pitch_acc_next = '0;
                if (fill_reg >= frame_len)
                    state_next = ST_SCAN;
                else
                    state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                ram_raddr = head_reg + idx_reg + PTR_W'(1);
                if ((idx_reg == '0) && (ram_rdata != header_byte_reg))
                begin
                    // No header at the front: drop one byte, hunt on
                    head_next  = head_reg + PTR_W'(1);
                    fill_next  = fill_reg - CNT_W'(1);
                    state_next = ST_CHECK;
                end
                else
                begin
                    if (idx_ext < payload_len)
                    begin
                        crc_next = crc16_byte(crc_reg, ram_rdata);
                        if (yaw_hit)
                            yaw_acc_next[{yaw_dist[1:0], 3'b000} +: 8] = ram_rdata;
                        if (pitch_hit)
                            pitch_acc_next[{pitch_dist[1:0], 3'b000} +: 8] = ram_rdata;
                    end
                    if (idx_ext == payload_len)
                        crc_lo_next = ram_rdata;

                    if (idx_ext == frame_len - CNT_W'(1))
                    begin
                        if ({ram_rdata, crc_lo_reg} == crc_reg)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            head_next  = head_reg + PTR_W'(1);
                            fill_next  = fill_reg - CNT_W'(1);
                            state_next = ST_CHECK;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + PTR_W'(1);
                    end
                end
            end

            ST_EMIT:
            begin
                // Hold until the output register is free, then consume the frame
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    yaw_out_next   = yaw_acc_reg;
                    pitch_out_next = pitch_acc_reg;
                    head_next      = head_reg + PTR_W'(frame_len);
                    fill_next      = fill_reg - frame_len;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        crc_reg       <= crc_next;
        crc_lo_reg    <= crc_lo_next;
        yaw_acc_reg   <= yaw_acc_next;
        pitch_acc_reg <= pitch_acc_next;
        yaw_out_reg   <= yaw_out_next;
        pitch_out_reg <= pitch_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign yaw_bits   = yaw_out_reg;
    assign pitch_bits = pitch_out_reg;

endmodule

`default_nettype wire

/* verif/crc16_header_frame_deframer_tb.sv */
// ============================================================================
// crc16_header_frame_deframer testbench
// Feeds serial bytes into the deframer: directed frames first, then random
// traffic of good, corrupted and cut frames mixed with noise. The expected
// yaw and pitch words come from a byte-level model of the hunt window.
// ============================================================================

module testbench;

    import chfd_pkg::*;

    localparam int     SETTLE_CYCLES     = 1500;    // worst hunt pass plus margin
    localparam longint CYCLE_LIMIT       = 900000;
    localparam int     RANDOM_ITEMS      = 480;
    localparam int     PHASE_ITEMS       = 120;
    localparam int     MAX_REPORTS       = 10;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_CUT
    } frame_kind_t;

    typedef struct packed {
        logic [31:0] yaw;
        logic [31:0] pitch;
    } angle_pair_t;

    // ------------------------------------------------------------------------
    // Clock, DUT signals and instance
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] yaw_bits;
    logic [31:0] pitch_bits;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    crc16_header_frame_deframer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .yaw_bits   (yaw_bits),
        .pitch_bits (pitch_bits),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // Window model: our own copy of the registers and the hunt window
    // ------------------------------------------------------------------------
    logic [7:0]  win [0:MAX_FRAME_LEN-1];
    int          win_fill;
    logic [6:0]  len_reg;
    logic [7:0]  hdr_reg;
    logic [5:0]  yaw_off_reg;
    logic [5:0]  pitch_off_reg;

    angle_pair_t angle_q [$];       // frames predicted but not yet seen
    angle_pair_t head_pair;
    int          err_count       = 0;
    int          items_sent      = 0;
    longint      cycle_count     = 0;

    // Length actually used for framing: register clamped to the legal span
    function automatic int frame_span();
        int l;
        l = len_reg;
        if (l < MIN_FRAME_LEN)
            l = MIN_FRAME_LEN;
        if (l > MAX_FRAME_LEN)
            l = MAX_FRAME_LEN;
        return l;
    endfunction

    // One byte of the reflected CRC, fed a data bit at a time
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] r;
        r = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ d[i])
                r = {1'b0, r[15:1]} ^ CRC_POLY;
            else
                r = {1'b0, r[15:1]};
        end
        return r;
    endfunction

    // Little-endian word; bytes from the CRC trailer onward read as zero
    function automatic logic [31:0] word_at(input int off, input int payload);
        logic [31:0] w;
        w = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (off + k < payload)
                w[8*k +: 8] = win[off + k];
        end
        return w;
    endfunction

    function automatic void drop_window(input int n);
        if (n >= win_fill)
            win_fill = 0;
        else
        begin
            for (int i = 0; i < win_fill - n; i++)
                win[i] = win[i + n];
            win_fill -= n;
        end
    endfunction

    // Advance the model by one accepted byte; queue at most one frame
    function automatic void deframe_byte(input logic [7:0] b);
        int          span;
        logic [15:0] crc;
        logic [15:0] trailer;
        angle_pair_t pair;
        bit          emitted;
        span    = frame_span();
        emitted = 1'b0;
        if (win_fill >= MAX_FRAME_LEN)
            drop_window(1);
        win[win_fill] = b;
        win_fill++;
        while (!emitted && win_fill >= span)
        begin
            if (win[0] != hdr_reg)
                drop_window(1);
            else
            begin
                crc = CRC_INIT;
                for (int i = 0; i < span - 2; i++)
                    crc = crc_step(crc, win[i]);
                trailer = {win[span - 1], win[span - 2]};
                if (crc == trailer)
                begin
                    pair.yaw   = word_at(yaw_off_reg, span - 2);
                    pair.pitch = word_at(pitch_off_reg, span - 2);
                    angle_q.push_back(pair);
                    drop_window(span);
                    emitted = 1'b1;
                end
                else
                    drop_window(1);
            end
        end
    endfunction

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch: %s expected %h got %h (cycle %0d)", what, want, got,
                     cycle_count);
    endfunction

    // ------------------------------------------------------------------------
    // Output checker: compare every accepted frame with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (angle_q.size() == 0)
                note_mismatch("frame with none pending, yaw", 32'h0, yaw_bits);
            else
            begin
                head_pair = angle_q.pop_front();
                if (yaw_bits !== head_pair.yaw)
                    note_mismatch("yaw_bits", head_pair.yaw, yaw_bits);
                if (pitch_bits !== head_pair.pitch)
                    note_mismatch("pitch_bits", head_pair.pitch, pitch_bits);
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL crc16_header_frame_deframer");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: rotate a stall pattern; a hold-off request forces ready low
    // for a counted stretch regardless of the pattern
    // ------------------------------------------------------------------------
    logic [15:0] ready_pattern = 16'hFFFF;
    int          hold_request  = 0;
    int          hold_left     = 0;

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready     <= ready_pattern[0];
            ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    // ------------------------------------------------------------------------
    // Sender: bytes go out in bursts of random length with random gaps
    // ------------------------------------------------------------------------
    int burst_left = 0;
    bit send_gaps  = 1'b1;

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = send_gaps ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        // hold the word until the block takes it
        do
            @(posedge clk);
        while (!in_ready);
        deframe_byte(b);
        items_sent++;
    endtask

    // Build a frame for the current header byte and send it, whole or damaged.
    // fill_byte < 0 gives random payload, sometimes seeded with false headers.
    task automatic send_frame(input int span, input frame_kind_t kind, input int fill_byte);
        logic [7:0]  fb [0:MAX_FRAME_LEN-1];
        logic [15:0] crc;
        int          stop;
        int          k;
        fb[0] = hdr_reg;
        crc   = crc_step(CRC_INIT, fb[0]);
        for (int i = 1; i < span - 2; i++)
        begin
            if (fill_byte >= 0)
                fb[i] = fill_byte[7:0];
            else if ($urandom_range(0, 7) == 0)
                fb[i] = hdr_reg;
            else
                fb[i] = 8'($urandom_range(0, 255));
            crc = crc_step(crc, fb[i]);
        end
        fb[span - 2] = crc[7:0];
        fb[span - 1] = crc[15:8];
        stop = span;
        if (kind == FRAME_BAD_CRC)
        begin
            k     = $urandom_range(1, span - 1);
            fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        else if (kind == FRAME_CUT)
            stop = $urandom_range(1, span - 1);
        for (int i = 0; i < stop; i++)
            send_byte(fb[i]);
    endtask

    // Drop valid, wait for every predicted frame, then let any hunt finish
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (angle_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------
    task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        apb_access(idx, 1'b0, 32'h0, got);
        if (got !== want)
            note_mismatch("register readback", want, got);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] unused_rd;
        logic [31:0] want;
        apb_access(idx, 1'b1, value, unused_rd);
        want = '0;
        case (idx)
            REG_FRAME_LEN:
            begin
                len_reg    = value[6:0];
                want[6:0]  = value[6:0];
            end
            REG_HEADER:
            begin
                hdr_reg    = value[7:0];
                want[7:0]  = value[7:0];
            end
            REG_YAW_OFF:
            begin
                yaw_off_reg = value[5:0];
                want[5:0]   = value[5:0];
            end
            default:
            begin
                pitch_off_reg = value[5:0];
                want[5:0]     = value[5:0];
            end
        endcase
        check_register(idx, want);
    endtask

    task automatic apply_settings(input int len, input int hdr, input int yaw, input int pitch);
        set_register(REG_FRAME_LEN, len);
        set_register(REG_HEADER, hdr);
        set_register(REG_YAW_OFF, yaw);
        set_register(REG_PITCH_OFF, pitch);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_register_reset();
        check_register(REG_FRAME_LEN, 32'(FRAME_LEN_RST));
        check_register(REG_HEADER, 32'(HEADER_RST));
        check_register(REG_YAW_OFF, 32'(YAW_OFF_RST));
        check_register(REG_PITCH_OFF, 32'(PITCH_OFF_RST));
    endtask

    task automatic test_directed_frames();
        // reset settings: 32-byte frame, header 0x53
        send_frame(32, FRAME_GOOD, -1);
        wait_drained();
        // length below the minimum runs as 12; yaw at the header, pitch past payload
        apply_settings(5, 8'h00, 0, 63);
        send_byte(8'hFF);
        send_frame(12, FRAME_BAD_CRC, 0);
        send_frame(12, FRAME_GOOD, 0);
        wait_drained();
        // all-ones bytes; yaw straddles the CRC trailer
        apply_settings(12, 8'hFF, 7, 58);
        send_frame(12, FRAME_GOOD, 8'hFF);
        send_frame(12, FRAME_CUT, -1);
        send_frame(12, FRAME_GOOD, -1);
        wait_drained();
    endtask

    // Hold bytes under a long frame, then shrink the frame: the next word
    // hunts the held bytes and leftovers surface one frame per word.
    task automatic test_length_lowered();
        apply_settings(127, 8'hA5, 3, 4);    // above the maximum runs as 64
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        send_frame(12, FRAME_GOOD, -1);
        send_frame(12, FRAME_GOOD, -1);
        repeat (5) send_byte(8'($urandom_range(0, 255)));
        wait_drained();
        set_register(REG_FRAME_LEN, 12);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        wait_drained();
    endtask

    // Receiver holds off while frames keep coming, so the block backs up
    // and stalls its input; afterwards the sender waits for the backlog.
    task automatic test_output_hold_off();
        apply_settings(12, $urandom_range(0, 255), 1, 5);
        ready_pattern = 16'hFFFF;
        send_gaps     = 1'b0;
        hold_request  = 3000;
        repeat (12) send_frame(12, FRAME_GOOD, -1);
        send_gaps = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int items_start;
        int phase;
        int budget;
        int kind;
        int len;
        items_start  = items_sent;
        phase        = 0;
        while (items_sent - items_start < RANDOM_ITEMS)
        begin
            case (phase)
                0: apply_settings(12, 8'h00, 0, 58);
                1: apply_settings(64, 8'hFF, 58, 1);
                2: apply_settings(0, $urandom_range(0, 255), 63, 0);
                default:
                begin
                    // mostly short frames; long and out-of-range lengths now and then
                    if ($urandom_range(0, 9) == 0)
                        len = $urandom_range(65, 127);
                    else if ($urandom_range(0, 4) == 0)
                        len = $urandom_range(21, 64);
                    else
                        len = $urandom_range(12, 20);
                    apply_settings(len, $urandom_range(0, 255), $urandom_range(0, 63),
                                   $urandom_range(0, 63));
                end
            endcase
            // some phases run the receiver without stalls, others the sender without gaps
            ready_pattern = (phase % 3 == 0) ? 16'hFFFF :
                            (16'($urandom_range(0, 65535)) | 16'h1);
            send_gaps     = (phase % 4 != 1);
            budget        = items_sent + PHASE_ITEMS;
            while (items_sent < budget)
            begin
                kind = $urandom_range(0, 9);
                if (kind <= 5)
                    send_frame(frame_span(), FRAME_GOOD, -1);
                else if (kind == 6)
                    send_frame(frame_span(), FRAME_BAD_CRC, -1);
                else if (kind == 7)
                    send_frame(frame_span(), FRAME_CUT, -1);
                else
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
            wait_drained();
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        win_fill      = 0;
        len_reg       = FRAME_LEN_RST;
        hdr_reg       = HEADER_RST;
        yaw_off_reg   = YAW_OFF_RST;
        pitch_off_reg = PITCH_OFF_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_reset();
        test_directed_frames();
        test_length_lowered();
        test_output_hold_off();
        test_random_traffic();
        wait_drained();

        if (err_count == 0)
            $display("PASS crc16_header_frame_deframer");
        else
            $display("FAIL crc16_header_frame_deframer");
        $finish;
    end

endmodule
